// ===== hdl/finite_context_model_counters_defines.svh =====
// Assertion macros for the checker file of the context model.
`ifndef FINITE_CONTEXT_MODEL_COUNTERS_DEFINES_SVH
`define FINITE_CONTEXT_MODEL_COUNTERS_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define FCMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FCMC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/fcmc_pkg.sv =====
`default_nettype none

package fcmc_pkg;

    localparam int INDEX_BITS   = 16;
    localparam int COUNTER_BITS = 16;

    localparam int ROWS      = 1 << INDEX_BITS;
    localparam int ROW_BITS  = 4 * COUNTER_BITS;
    localparam int CUM_BITS  = 26;
    localparam int USED_BITS = 16;

    // Width of one symbol weight: offset + scale * count.
    localparam int W_BITS   = ((COUNTER_BITS + 8 > 16) ? COUNTER_BITS + 8 : 16) + 1;
    // Width of one running-sum step before saturation.
    localparam int SUM_BITS = ((W_BITS > CUM_BITS) ? W_BITS : CUM_BITS) + 1;
    // Width for comparing a counter against max_count.
    localparam int CMP_BITS = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

    localparam logic [CUM_BITS-1:0] CUM_MAX = {CUM_BITS{1'b1}};

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_ALPHABET_FOUR = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CONTEXT_ORDER = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WEIGHT_OFFSET = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WEIGHT_SCALE  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_COUNT     = 3'd4;

    localparam logic CMD_CODE  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic ld_in;    // latch the accepted symbol
        logic rd_en;    // read the counter row of the current context
        logic calc_en;  // register weights and the updated row
        logic commit;   // write back, shift context, load the result
        logic clr_out;  // load the all-zero result and zero the context
        logic clr_wr;   // write one zero row of the clearing sweep
    } fcmc_cmd_t;

    typedef struct packed {
        logic out_free;
        logic sweep_last;
    } fcmc_stat_t;

endpackage

`default_nettype wire

// ===== hdl/finite_context_model_counters.sv =====
// Channel   Direction  Handshake          Payload
// config    in         cfg_wr_en          cfg_addr, cfg_wdata
// symbol    in         s_valid / s_ready  s_cmd, s_symbol
// result    out        m_valid / m_ready  m_cum_freq_0..3, m_context_used
//
// A coded symbol passes three steps: accept with the row read, weight multiply
// with the counter update, then the saturating sums with write-back.
// These are set by the registered read and the write-back of the counter row.
// After reset, and after a clear beat, a sweep zeroes one row per cycle over
// all 65536 rows, during which no beat is accepted; config writes still land.
// A result held by m_ready low stalls the write-back until the output is free.
`default_nettype none

module finite_context_model_counters import fcmc_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_cmd,
    input  wire logic [1:0]               s_symbol,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [CUM_BITS-1:0]           m_cum_freq_0,
    output logic [CUM_BITS-1:0]           m_cum_freq_1,
    output logic [CUM_BITS-1:0]           m_cum_freq_2,
    output logic [CUM_BITS-1:0]           m_cum_freq_3,
    output logic [USED_BITS-1:0]          m_context_used
);

    fcmc_cmd_t             cmd;
    fcmc_stat_t            stat;
    logic                  ram_wr_en;
    logic [INDEX_BITS-1:0] ram_wr_addr;
    logic [ROW_BITS-1:0]   ram_wr_data;
    logic                  ram_rd_en;
    logic [INDEX_BITS-1:0] ram_rd_addr;
    logic [ROW_BITS-1:0]   ram_rd_data;

    fcmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .stat    (stat),
        .cmd     (cmd)
    );

    fcmc_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_symbol       (s_symbol),
        .cmd            (cmd),
        .stat           (stat),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cum_freq_0   (m_cum_freq_0),
        .m_cum_freq_1   (m_cum_freq_1),
        .m_cum_freq_2   (m_cum_freq_2),
        .m_cum_freq_3   (m_cum_freq_3),
        .m_context_used (m_context_used)
    );

    fcmc_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ===== hdl/fcmc_ram.sv =====
`default_nettype none

module fcmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/fcmc_datapath.sv =====
`default_nettype none

module fcmc_datapath import fcmc_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic [1:0]               s_symbol,
    input  wire fcmc_cmd_t                cmd,
    output fcmc_stat_t                    stat,
    output logic                          ram_wr_en,
    output logic [INDEX_BITS-1:0]         ram_wr_addr,
    output logic [ROW_BITS-1:0]           ram_wr_data,
    output logic                          ram_rd_en,
    output logic [INDEX_BITS-1:0]         ram_rd_addr,
    input  wire logic [ROW_BITS-1:0]      ram_rd_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [CUM_BITS-1:0]           m_cum_freq_0,
    output logic [CUM_BITS-1:0]           m_cum_freq_1,
    output logic [CUM_BITS-1:0]           m_cum_freq_2,
    output logic [CUM_BITS-1:0]           m_cum_freq_3,
    output logic [USED_BITS-1:0]          m_context_used
);

    localparam logic [4:0] MAX_ORD_BIN  = 5'(INDEX_BITS);
    localparam logic [4:0] MAX_ORD_QUAD = 5'((INDEX_BITS / 2 < 1) ? 1 : INDEX_BITS / 2);

    logic                    alpha_reg;
    logic [4:0]              order_reg;
    logic [15:0]             offset_reg;
    logic [7:0]              scale_reg;
    logic [15:0]             maxc_reg;

    logic [INDEX_BITS-1:0]   ctx_reg;
    logic [INDEX_BITS-1:0]   sweep_reg;
    logic [1:0]              sym_reg;
    logic [W_BITS-1:0]       w_reg [4];
    logic [W_BITS-1:0]       w_next [4];
    logic [ROW_BITS-1:0]     row_reg;
    logic [ROW_BITS-1:0]     row_next;
    logic [CUM_BITS-1:0]     cum_reg [4];
    logic [CUM_BITS-1:0]     cum_next [4];
    logic [USED_BITS-1:0]    used_reg;
    logic                    m_valid_reg;

    logic [4:0]              ord_min;
    logic [4:0]              ord_eff;
    logic [5:0]              keep_sh;
    logic [INDEX_BITS-1:0]   keep_mask;
    logic [INDEX_BITS-1:0]   ctx_next;
    logic [INDEX_BITS+USED_BITS-1:0] ctx_wide;

    // Effective context order and the new context after shifting in the symbol.
    always_comb begin
        ord_min = (order_reg == 5'd0) ? 5'd1 : order_reg;
        if (alpha_reg) begin
            ord_eff = (ord_min > MAX_ORD_QUAD) ? MAX_ORD_QUAD : ord_min;
            keep_sh = {ord_eff - 5'd1, 1'b0};
        end else begin
            ord_eff = (ord_min > MAX_ORD_BIN) ? MAX_ORD_BIN : ord_min;
            keep_sh = {1'b0, ord_eff - 5'd1};
        end
        keep_mask = ~({INDEX_BITS{1'b1}} << keep_sh);
        ctx_next  = ((ctx_reg & keep_mask) << (alpha_reg ? 2'd2 : 2'd1))
                    | INDEX_BITS'(sym_reg);
        ctx_wide  = {{USED_BITS{1'b0}}, ctx_reg};
    end

    // Weights of the fetched row, and the row after the counter update.
    always_comb begin
        logic [COUNTER_BITS-1:0] cnt_n;
        logic [COUNTER_BITS-1:0] cnt_sel;
        logic [COUNTER_BITS-1:0] cnt_inc;
        logic [COUNTER_BITS-1:0] v;
        logic                    trig;
        cnt_sel = '0;
        for (int n = 0; n < 4; n++) begin
            cnt_n = ram_rd_data[n*COUNTER_BITS +: COUNTER_BITS];
            w_next[n] = W_BITS'(offset_reg) + W_BITS'(scale_reg) * W_BITS'(cnt_n);
            if (sym_reg == 2'(n)) begin
                cnt_sel = cnt_n;
            end
        end
        cnt_inc = cnt_sel + COUNTER_BITS'(1);
        trig = (CMP_BITS'(cnt_inc) >= CMP_BITS'(maxc_reg)) || (cnt_inc == '1);
        for (int n = 0; n < 4; n++) begin
            v = (sym_reg == 2'(n)) ? cnt_inc : ram_rd_data[n*COUNTER_BITS +: COUNTER_BITS];
            if (trig && (n < 2 || alpha_reg)) begin
                v = v >> 1;
            end
            row_next[n*COUNTER_BITS +: COUNTER_BITS] = v;
        end
    end

    // Saturating cumulative sums from the highest symbol down.
    always_comb begin
        logic [CUM_BITS-1:0] run;
        logic [SUM_BITS-1:0] s;
        run = '0;
        for (int n = 3; n >= 0; n--) begin
            if (n < 2 || alpha_reg) begin
                s   = SUM_BITS'(run) + SUM_BITS'(w_reg[n]);
                run = (s > SUM_BITS'(CUM_MAX)) ? CUM_MAX : s[CUM_BITS-1:0];
                cum_next[n] = run;
            end else begin
                cum_next[n] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg   <= 1'b0;
            order_reg   <= 5'd8;
            offset_reg  <= 16'd1;
            scale_reg   <= 8'd1;
            maxc_reg    <= 16'hFFFF;
            ctx_reg     <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ALPHABET_FOUR: alpha_reg  <= cfg_wdata[0];
                    REG_CONTEXT_ORDER: order_reg  <= cfg_wdata[4:0];
                    REG_WEIGHT_OFFSET: offset_reg <= cfg_wdata;
                    REG_WEIGHT_SCALE:  scale_reg  <= cfg_wdata[7:0];
                    REG_MAX_COUNT:     maxc_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.clr_wr) begin
                sweep_reg <= sweep_reg + INDEX_BITS'(1);
            end
            if (cmd.commit) begin
                ctx_reg <= ctx_next;
            end else if (cmd.clr_out) begin
                ctx_reg <= '0;
            end
            if (cmd.commit || cmd.clr_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            sym_reg <= alpha_reg ? s_symbol : {1'b0, s_symbol[0]};
        end
        if (cmd.calc_en) begin
            w_reg   <= w_next;
            row_reg <= row_next;
        end
        if (cmd.commit) begin
            cum_reg  <= cum_next;
            used_reg <= ctx_wide[USED_BITS-1:0];
        end else if (cmd.clr_out) begin
            for (int n = 0; n < 4; n++) begin
                cum_reg[n] <= '0;
            end
            used_reg <= '0;
        end
    end

    assign ram_wr_en   = cmd.commit || cmd.clr_wr;
    assign ram_wr_addr = cmd.clr_wr ? sweep_reg : ctx_reg;
    assign ram_wr_data = cmd.clr_wr ? '0 : row_reg;
    assign ram_rd_en   = cmd.rd_en;
    assign ram_rd_addr = ctx_reg;

    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.sweep_last = (sweep_reg == '1);

    assign m_valid        = m_valid_reg;
    assign m_cum_freq_0   = cum_reg[0];
    assign m_cum_freq_1   = cum_reg[1];
    assign m_cum_freq_2   = cum_reg[2];
    assign m_cum_freq_3   = cum_reg[3];
    assign m_context_used = used_reg;

endmodule

`default_nettype wire

// ===== hdl/fcmc_ctrl.sv =====
`default_nettype none

module fcmc_ctrl import fcmc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_cmd,
    input  wire fcmc_stat_t stat,
    output fcmc_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CLR_RES
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;
    logic   accept;

    assign accept = s_valid && s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.ld_in = 1'b1;
                    if (s_cmd == CMD_CLEAR) begin
                        state_next = ST_CLR_RES;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.calc_en = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLR_RES: begin
                if (stat.out_free) begin
                    cmd.clr_out = 1'b1;
                    state_next  = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

`default_nettype wire

// ===== hdl/fcmc_checker.sv =====
`default_nettype none
`include "finite_context_model_counters_defines.svh"

module fcmc_checker import fcmc_pkg::*; (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic [CUM_BITS-1:0]      m_cum_freq_0,
    input wire logic [CUM_BITS-1:0]      m_cum_freq_1,
    input wire logic [CUM_BITS-1:0]      m_cum_freq_2,
    input wire logic [CUM_BITS-1:0]      m_cum_freq_3
);

    // Neither a result nor s_ready is shown right after reset.
    `FCMC_ASSERT_RST(a_reset_idle, !aresetn |=> !m_valid && !s_ready, "busy after reset")

    // A stalled result stays on the port.
    `FCMC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "result dropped while stalled")

    // A beat keeps the block busy for at least the read and multiply cycles.
    `FCMC_ASSERT(a_busy_after_beat, s_valid && s_ready |=> !s_ready ##1 !s_ready, "ready too early")

    // Sums run from the highest symbol down, so they never grow upward.
    `FCMC_ASSERT(a_cum_order, m_valid |-> (m_cum_freq_0 >= m_cum_freq_1) && (m_cum_freq_1 >= m_cum_freq_2) && (m_cum_freq_2 >= m_cum_freq_3), "cumulative order broken")

endmodule

bind finite_context_model_counters fcmc_checker u_fcmc_checker (.*);

`default_nettype wire
